@@ src/mwms_pkg.sv @@
package mwms_pkg;

   localparam int CAP_W     = 16;
   localparam int WIN_LEN_W = 9;
   localparam int GAIN_W    = 24;
   localparam int SUM_W     = 32;
   localparam int APB_DW    = 32;
   localparam int APB_AW    = 3;

   typedef logic [CAP_W-1:0]     cap_type;
   typedef logic [WIN_LEN_W-1:0] win_len_type;
   typedef logic [GAIN_W-1:0]    gain_type;
   typedef logic [SUM_W-1:0]     sum_type;

   // register select is paddr[2]
   localparam logic REG_WINDOW_LEN = 1'b0;

   localparam win_len_type WIN_LEN_RESET = WIN_LEN_W'(1);
   localparam sum_type     SUM_SAT       = '1;

endpackage

@@ src/mwms_req_if.sv @@
interface mwms_req_if
   import mwms_pkg::*;
   ();
   logic    valid;
   logic    ready;
   cap_type capacity;
   logic    planned;
   logic    last_day;

   modport source (output valid, output capacity, output planned, output last_day,
                   input ready);
   modport sink   (input valid, input capacity, input planned, input last_day,
                   output ready);
endinterface

@@ src/mwms_rsp_if.sv @@
interface mwms_rsp_if
   import mwms_pkg::*;
   ();
   logic    valid;
   logic    ready;
   sum_type best_total;

   modport source (output valid, output best_total, input ready);
   modport sink   (input valid, input best_total, output ready);
endinterface

@@ src/masked_window_max_sum_top.sv @@
// masked_window_max_sum_top
// Each req beat is one day: capacity, planned bit and last_day mark. Planned
// days add capacity to a base sum; rest days add capacity as gain, and the
// block tracks the best gain over any run of window_len consecutive days.
// The beat with last_day set produces one rsp beat, best_total = base sum
// plus best window gain (saturating at 32 bits); all other beats produce none.
// If a sequence is shorter than the window, the gain of all its days is used.
// Recent gains sit in a shift chain of WINDOW_MAX cells; the cell window_len
// back supplies the gain that leaves the running window.
// Throughput: one day per cycle while req_ready is high. The result passes
// through stage A and then the output register after the last_day beat.
// window_len is written over the APB port at address 0 (write only while
// idle); it reads back, resets to 1, 0 acts as 1 and values above WINDOW_MAX
// act as WINDOW_MAX.
// Reset (synchronous) clears the running sums, the output stage and window_len;
// the gain chain is not cleared and needs no clearing pass.
// When rsp is stalled the result is held; one further result can wait in the
// internal stage, after which req_ready drops until rsp drains.
module masked_window_max_sum_top
   import mwms_pkg::*;
#(
   parameter int WINDOW_MAX = 256,
   parameter int DAYS_MAX   = 65536
) (
   input  logic              clock,
   input  logic              reset,
   mwms_req_if.sink          req_bus,
   mwms_rsp_if.source        rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [APB_AW-1:0] paddr,
   input  logic [APB_DW-1:0] pwdata,
   output logic [APB_DW-1:0] prdata,
   output logic              pready
);

   localparam int DAY_CAP = (DAYS_MAX > WINDOW_MAX) ? DAYS_MAX : WINDOW_MAX;
   localparam int WW      = $clog2(WINDOW_MAX + 1);
   localparam int IW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int DW      = $clog2(DAY_CAP + 1);

   win_len_type    window_len_ff;
   logic [DW-1:0]  days_ff, days_in;
   sum_type        base_ff, base_in;
   gain_type       wgain_ff, wgain_in;
   gain_type       best_ff, best_in;
   logic           a_valid_ff, a_valid_in;
   sum_type        a_base_ff, a_base_in;
   gain_type       a_gain_ff, a_gain_in;
   logic           rsp_valid_ff, rsp_valid_in;
   sum_type        rsp_total_ff, rsp_total_in;

   logic [WW-1:0]  win_eff;
   logic [IW-1:0]  tap_sel;
   logic           accept, rsp_free, full_before, full_after;
   cap_type        gain, old_gain;
   logic [SUM_W:0] base_sum_ext, total_ext;
   cap_type        chain [WINDOW_MAX];
   cap_type        taps  [WINDOW_MAX];

   assign pready = 1'b1;
   assign prdata = APB_DW'(window_len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= WIN_LEN_RESET;
      end else if (psel && penable && pwrite && paddr[2] == REG_WINDOW_LEN) begin
         window_len_ff <= pwdata[WIN_LEN_W-1:0];
      end
   end

   always_comb begin
      if (window_len_ff == '0) begin
         win_eff = WW'(1);
      end else if (32'(window_len_ff) > 32'(WINDOW_MAX)) begin
         win_eff = WW'(WINDOW_MAX);
      end else begin
         win_eff = WW'(window_len_ff);
      end
   end

   assign tap_sel = IW'(win_eff - WW'(1));

   assign rsp_free       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready  = !a_valid_ff || rsp_free;
   assign accept         = req_bus.valid && req_bus.ready;
   assign gain           = req_bus.planned ? '0 : req_bus.capacity;

   genvar k;
   generate
      for (k = 0; k < WINDOW_MAX; k++) begin : g_cell
         mwms_cell #(
            .INDEX (k),
            .IDX_W (IW)
         ) u_cell (
            .clock    (clock),
            .shift    (accept),
            .gain_in  ((k == 0) ? gain : chain[(k == 0) ? 0 : k-1]),
            .tap_sel  (tap_sel),
            .gain_out (chain[k]),
            .tap_out  (taps[k])
         );
      end
   endgenerate

   always_comb begin
      old_gain = '0;
      for (int i = 0; i < WINDOW_MAX; i++) begin
         old_gain = old_gain | taps[i];
      end
   end

   always_comb begin
      full_before  = 32'(days_ff) >= 32'(win_eff);
      base_sum_ext = {1'b0, base_ff} + (SUM_W+1)'(req_bus.capacity);
      if (req_bus.planned) begin
         base_in = base_sum_ext[SUM_W] ? SUM_SAT : base_sum_ext[SUM_W-1:0];
      end else begin
         base_in = base_ff;
      end
      wgain_in = wgain_ff - (full_before ? GAIN_W'(old_gain) : '0) + GAIN_W'(gain);
      days_in  = (32'(days_ff) < 32'(DAY_CAP)) ? days_ff + DW'(1) : days_ff;
      full_after = 32'(days_in) >= 32'(win_eff);
      best_in  = (full_after && wgain_in > best_ff) ? wgain_in : best_ff;
      a_base_in = base_in;
      a_gain_in = full_after ? best_in : wgain_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         days_ff  <= '0;
         base_ff  <= '0;
         wgain_ff <= '0;
         best_ff  <= '0;
      end else if (accept) begin
         if (req_bus.last_day) begin
            days_ff  <= '0;
            base_ff  <= '0;
            wgain_ff <= '0;
            best_ff  <= '0;
         end else begin
            days_ff  <= days_in;
            base_ff  <= base_in;
            wgain_ff <= wgain_in;
            best_ff  <= best_in;
         end
      end
   end

   // result stage A, then the output register
   always_comb begin
      total_ext = {1'b0, a_base_ff} + (SUM_W+1)'(a_gain_ff);
      rsp_total_in = total_ext[SUM_W] ? SUM_SAT : total_ext[SUM_W-1:0];
      rsp_valid_in = rsp_free ? a_valid_ff : rsp_valid_ff;
      priority if (accept && req_bus.last_day) begin
         a_valid_in = 1'b1;
      end else if (a_valid_ff && rsp_free) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_bus.last_day) begin
         a_base_ff <= a_base_in;
         a_gain_ff <= a_gain_in;
      end
      if (rsp_free && a_valid_ff) begin
         rsp_total_ff <= rsp_total_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.best_total = rsp_total_ff;

endmodule

@@ src/mwms_cell.sv @@
module mwms_cell
   import mwms_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int IDX_W = 8
) (
   input  logic             clock,
   input  logic             shift,
   input  cap_type          gain_in,
   input  logic [IDX_W-1:0] tap_sel,
   output cap_type          gain_out,
   output cap_type          tap_out
);

   cap_type gain_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         gain_ff <= gain_in;
      end
   end

   assign gain_out = gain_ff;
   assign tap_out  = (tap_sel == IDX_W'(INDEX)) ? gain_ff : '0;

endmodule

@@ src/mwms_checker.sv @@
module mwms_checker
   import mwms_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    req_last_day,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input sum_type rsp_best_total
);

   logic last_acc;
   assign last_acc = req_valid && req_ready && req_last_day;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_best_total))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !last_acc && !$past(last_acc) |=> !rsp_valid)
      else $error("rsp beat without a last_day beat");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled while output is empty");

endmodule

bind masked_window_max_sum_top mwms_checker u_mwms_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_last_day   (req_bus.last_day),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_best_total (rsp_bus.best_total)
);
